// ===== rtl/core/sart_pkg.sv =====
// Shared types and constants for the sorted address range table.
// No dependencies; used by every module in rtl/core.
`timescale 1ns / 1ps

package sart_pkg;

    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 6;

    typedef enum logic
    {
        FUNC_INSERT = 1'b0,
        FUNC_LOOKUP = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_SKIP = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_CMP,
        S_TREE,
        S_RESULT
    } state_t;

    // One stored region, as handed from cell to cell
    typedef struct packed
    {
        logic              valid;
        logic [DATA_W-1:0] begin_addr;
        logic [DATA_W-1:0] end_addr;
        logic [DATA_W-1:0] offset;
    } entry_t;

    // Broadcast from the controller to every cell
    typedef struct packed
    {
        logic              ins;
        logic              look;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] new_begin;
        logic [DATA_W-1:0] new_offset;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/sorted_address_range_table.sv =====
// Sorted address range table: a chain of cells ordered by region end address.
// Insert or lookup: every cell compares in S_CMP, the registered gather tree is walked in S_TREE,
// and S_RESULT loads the output registers. Skipped or full inserts go straight to S_RESULT.
// One word is in work at a time; the next is taken the cycle after the result is loaded, and
// S_RESULT holds while the output is stalled. Reset empties the table.
`timescale 1ns / 1ps

module sorted_address_range_table
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic [sart_pkg::DATA_W-1:0]         address,
    input  logic [sart_pkg::DATA_W-1:0]         length,
    input  logic [sart_pkg::DATA_W-1:0]         file_offset,
    input  logic                                name_allowed,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sart_pkg::STATUS_W-1:0]       status,
    output logic [sart_pkg::ENTRY_W-1:0]        entry_index,
    output logic [sart_pkg::DATA_W-1:0]         region_begin,
    output logic [sart_pkg::DATA_W-1:0]         region_end,
    output logic [sart_pkg::DATA_W-1:0]         region_offset
);
    import sart_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LEVELS = $clog2(TABLE_DEPTH);
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int WORD_W = 1 + IDX_W + 3 * DATA_W;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [LVL_W-1:0]   lvl_reg;
    logic [LVL_W-1:0]   lvl_next;
    func_t              func_reg;
    func_t              func_next;
    logic [DATA_W-1:0]  key_reg;
    logic [DATA_W-1:0]  key_next;
    logic [DATA_W-1:0]  begin_reg;
    logic [DATA_W-1:0]  begin_next;
    logic [DATA_W-1:0]  offset_reg;
    logic [DATA_W-1:0]  offset_next;
    status_t            stat_reg;
    status_t            stat_next;
    logic               tree_reg;
    logic               tree_next;
    logic               front_ok_reg;
    logic               front_ok_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [ENTRY_W-1:0] index_reg;
    logic [ENTRY_W-1:0] index_next;
    logic [DATA_W-1:0]  rbegin_reg;
    logic [DATA_W-1:0]  rbegin_next;
    logic [DATA_W-1:0]  rend_reg;
    logic [DATA_W-1:0]  rend_next;
    logic [DATA_W-1:0]  roffset_reg;
    logic [DATA_W-1:0]  roffset_next;

    logic               accept;
    logic               load_out;
    logic               hit;
    cell_ctrl_t         ctrl;
    entry_t             ent_w  [TABLE_DEPTH];
    entry_t             left_w [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] gt_w;
    logic [TABLE_DEPTH-1:0] lgt_w;
    logic [TABLE_DEPTH-1:0] sel_w;
    logic [WORD_W-1:0]  leaf_w [TABLE_DEPTH];
    logic [WORD_W-1:0]  root_w;
    logic               root_hit;
    logic [IDX_W-1:0]   root_idx;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    assign ctrl = '{ins:  (state_reg == S_CMP) && (func_reg == FUNC_INSERT),
                    look: (state_reg == S_CMP) && (func_reg == FUNC_LOOKUP),
                    key: key_reg, new_begin: begin_reg, new_offset: offset_reg};

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                // head of the chain sees a filled neighbour with the lowest end
                assign left_w[i] = '{valid: 1'b1, default: '0};
                assign lgt_w[i]  = 1'b0;
            end
            else
            begin : g_link
                assign left_w[i] = ent_w[i-1];
                assign lgt_w[i]  = gt_w[i-1];
            end

            sart_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .left    (left_w[i]),
                .left_gt (lgt_w[i]),
                .ent     (ent_w[i]),
                .gt      (gt_w[i]),
                .sel     (sel_w[i])
            );

            assign leaf_w[i] = sel_w[i] ? {1'b1, IDX_W'(i), ent_w[i].begin_addr,
                                           ent_w[i].end_addr, ent_w[i].offset}
                                        : '0;
        end
    endgenerate

    sart_tree
    #(
        .WORD_W (WORD_W),
        .LEAVES (TABLE_DEPTH)
    )
    u_tree
    (
        .clk  (clk),
        .leaf (leaf_w),
        .root (root_w)
    );

    assign root_hit = root_w[WORD_W-1];
    assign root_idx = root_w[WORD_W-2 -: IDX_W];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        lvl_next      = lvl_reg;
        func_next     = func_reg;
        key_next      = key_reg;
        begin_next    = begin_reg;
        offset_next   = offset_reg;
        stat_next     = stat_reg;
        tree_next     = tree_reg;
        front_ok_next = front_ok_reg;
        load_out      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next   = func_t'(func);
                    begin_next  = address;
                    offset_next = file_offset;
                    if (func_t'(func) == FUNC_INSERT)
                    begin
                        key_next = address + length;
                        if (!name_allowed)
                        begin
                            stat_next  = ST_SKIP;
                            tree_next  = 1'b0;
                            state_next = S_RESULT;
                        end
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            stat_next  = ST_FULL;
                            tree_next  = 1'b0;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            stat_next  = ST_OK;
                            tree_next  = 1'b1;
                            state_next = S_CMP;
                        end
                    end
                    else
                    begin
                        key_next   = address;
                        stat_next  = ST_MISS;
                        tree_next  = 1'b1;
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                // an address below the first region's begin misses outright
                front_ok_next = ent_w[0].valid && (ent_w[0].begin_addr <= key_reg);
                if (func_reg == FUNC_INSERT)
                    count_next = count_reg + 1'b1;
                lvl_next   = '0;
                state_next = S_TREE;
            end
            S_TREE:
            begin
                lvl_next = lvl_reg + 1'b1;
                if (lvl_reg == LVL_W'(LEVELS))
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        hit = tree_reg && root_hit && ((func_reg == FUNC_INSERT) || front_ok_reg);

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        index_next     = index_reg;
        rbegin_next    = rbegin_reg;
        rend_next      = rend_reg;
        roffset_next   = roffset_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            if (hit)
            begin
                status_next  = ST_OK;
                index_next   = ENTRY_W'(root_idx);
                rbegin_next  = root_w[3*DATA_W-1 -: DATA_W];
                rend_next    = root_w[2*DATA_W-1 -: DATA_W];
                roffset_next = root_w[DATA_W-1:0];
            end
            else
            begin
                status_next  = tree_reg ? ST_MISS : stat_reg;
                index_next   = '0;
                rbegin_next  = '0;
                rend_next    = '0;
                roffset_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        begin_reg    <= begin_next;
        offset_reg   <= offset_next;
        stat_reg     <= stat_next;
        tree_reg     <= tree_next;
        front_ok_reg <= front_ok_next;
        status_reg   <= status_next;
        index_reg    <= index_next;
        rbegin_reg   <= rbegin_next;
        rend_reg     <= rend_next;
        roffset_reg  <= roffset_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_index   = index_reg;
    assign region_begin  = rbegin_reg;
    assign region_end    = rend_reg;
    assign region_offset = roffset_reg;

    a_one_sel: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_w))
        else $error("more than one cell selected");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // a placed entry must always come back through the tree
    a_insert_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && tree_reg && func_reg == FUNC_INSERT) |-> root_hit)
        else $error("inserted entry not found in gather tree");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && func_reg == FUNC_INSERT) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("entry count not advanced on insert");

endmodule

// ===== rtl/core/sart_cell.sv =====
// One cell of the sorted region chain: holds a single entry, shifts right on insert.
// Depends on sart_pkg.
`timescale 1ns / 1ps

module sart_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  sart_pkg::cell_ctrl_t ctrl,
    input  sart_pkg::entry_t    left,
    input  logic                left_gt,
    output sart_pkg::entry_t    ent,
    output logic                gt,
    output logic                sel
);
    import sart_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [DATA_W-1:0] begin_reg;
    logic [DATA_W-1:0] begin_next;
    logic [DATA_W-1:0] end_reg;
    logic [DATA_W-1:0] end_next;
    logic [DATA_W-1:0] offset_reg;
    logic [DATA_W-1:0] offset_next;
    logic              sel_reg;
    logic              sel_next;
    logic              take_left;
    logic              take_new;
    logic              load;

    assign ent = '{valid: valid_reg, begin_addr: begin_reg, end_addr: end_reg,
                   offset: offset_reg};
    assign gt  = valid_reg && (end_reg > ctrl.key);
    assign sel = sel_reg;

    always_comb
    begin
        // entries past the slot move one place right; the slot takes the new region
        take_left = ctrl.ins && left_gt;
        take_new  = ctrl.ins && left.valid && !left_gt && (!valid_reg || gt);
        load      = take_left || take_new;

        valid_next  = valid_reg;
        begin_next  = begin_reg;
        end_next    = end_reg;
        offset_next = offset_reg;
        if (take_left)
        begin
            valid_next  = left.valid;
            begin_next  = left.begin_addr;
            end_next    = left.end_addr;
            offset_next = left.offset;
        end
        else if (take_new)
        begin
            valid_next  = 1'b1;
            begin_next  = ctrl.new_begin;
            end_next    = ctrl.key;
            offset_next = ctrl.new_offset;
        end

        // lookup: first entry whose end exceeds the address, begin checked here
        if (ctrl.ins)
            sel_next = take_new;
        else if (ctrl.look)
            sel_next = gt && !left_gt && (begin_reg <= ctrl.key);
        else
            sel_next = sel_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            begin_reg  <= begin_next;
            end_reg    <= end_next;
            offset_reg <= offset_next;
        end
    end

    // filled cells form a prefix of the chain
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> left.valid)
        else $error("cell filled while its left neighbour is empty");

    // ends never decrease along the chain
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && left.valid) |-> (left.end_addr <= end_reg))
        else $error("end addresses out of order");

    a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> valid_reg)
        else $error("empty cell selected");

endmodule

// ===== rtl/core/sart_tree.sv =====
// Registered binary OR tree that gathers the single selected cell's word.
// Depends on sart_pkg only for style.
`timescale 1ns / 1ps

module sart_tree
#(
    parameter int WORD_W = 203,
    parameter int LEAVES = 64
)
(
    input  logic              clk,
    input  logic [WORD_W-1:0] leaf [LEAVES],
    output logic [WORD_W-1:0] root
);
    import sart_pkg::*;

    localparam int LEVELS = $clog2(LEAVES);
    localparam int SPAN   = 1 << LEVELS;

    logic [WORD_W-1:0] pad      [SPAN];
    logic [WORD_W-1:0] node_reg [1:SPAN-1];

    genvar i;
    genvar n;

    generate
        for (i = 0; i < SPAN; i++)
        begin : g_pad
            if (i < LEAVES)
            begin : g_leaf
                assign pad[i] = leaf[i];
            end
            else
            begin : g_zero
                assign pad[i] = '0;
            end
        end

        // heap layout: node n has children 2n and 2n+1, leaves sit at SPAN..2*SPAN-1
        for (n = 1; n < SPAN; n++)
        begin : g_node
            if (2 * n >= SPAN)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    node_reg[n] <= pad[2*n-SPAN] | pad[2*n+1-SPAN];
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    node_reg[n] <= node_reg[2*n] | node_reg[2*n+1];
                end
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule
